// File: rtl/sepq_pkg.sv
// Shared types and codes for the sorted event priority queue.
package sepq_pkg;

    localparam int OCC_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOKEY = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] event_time;
        logic [15:0] job_id;
        logic [7:0]  job_kind;
        logic [15:0] kind_serial;
        logic [15:0] service_time;
        logic [31:0] waited_time;
    } record_t;

    // Broadcast command to every cell of the chain.
    typedef struct packed {
        logic ins_go;
        logic del_go;
    } cmd_t;

endpackage

// File: rtl/sepq_req_if.sv
// Request channel: one queue operation per item.
interface sepq_req_if import sepq_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] event_time;
    logic [15:0] job_id;
    logic [7:0]  job_kind;
    logic [15:0] kind_serial;
    logic [15:0] service_time;
    logic [31:0] waited_time;

    modport source (
        output valid, operation, event_time, job_id, job_kind, kind_serial,
               service_time, waited_time,
        input  ready
    );
    modport sink (
        input  valid, operation, event_time, job_id, job_kind, kind_serial,
               service_time, waited_time,
        output ready
    );
endinterface

// File: rtl/sepq_rsp_if.sv
// Response channel: head record, occupancy and status after each operation.
interface sepq_rsp_if import sepq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             head_valid;
    logic [31:0]      head_time;
    logic [15:0]      head_job;
    logic [7:0]       head_kind;
    logic [15:0]      head_kind_serial;
    logic [15:0]      head_service;
    logic [31:0]      head_waited;
    logic [OCC_W-1:0] occupancy;
    logic [1:0]       status;

    modport source (
        output valid, head_valid, head_time, head_job, head_kind, head_kind_serial,
               head_service, head_waited, occupancy, status,
        input  ready
    );
    modport sink (
        input  valid, head_valid, head_time, head_job, head_kind, head_kind_serial,
               head_service, head_waited, occupancy, status,
        output ready
    );
endinterface

// File: rtl/sepq_cell.sv
// One slot of the sorted chain: holds a record and shifts with its neighbors.
module sepq_cell import sepq_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  record_t new_rec,
    input  logic [15:0] key_job,
    input  logic    sel,
    input  logic    left_greater,
    input  record_t left_rec,
    input  logic    left_used,
    input  record_t right_rec,
    input  logic    right_used,
    output record_t rec,
    output logic    used,
    output logic    greater,
    output logic    match,
    output record_t rec_next,
    output logic    used_next
);

    record_t rec_reg;
    logic    used_reg;

    assign rec     = rec_reg;
    assign used    = used_reg;
    // An empty slot counts as later than any key, so the chain stays monotone.
    assign greater = !used_reg || (rec_reg.event_time > new_rec.event_time);
    assign match   = used_reg && (rec_reg.job_id == key_job);

    always_comb
    begin
        rec_next  = rec_reg;
        used_next = used_reg;
        if (cmd.ins_go)
        begin
            if (left_greater)
            begin
                rec_next  = left_rec;
                used_next = left_used;
            end
            else if (greater)
            begin
                rec_next  = new_rec;
                used_next = 1'b1;
            end
        end
        else if (cmd.del_go && sel)
        begin
            rec_next  = right_rec;
            used_next = right_used;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

endmodule

// File: rtl/sepq_prefix.sv
// Inclusive prefix OR over the match flags, built as a log-depth tree.
module sepq_prefix #(
    parameter int N = 64
) (
    input  logic [N-1:0] bits,
    output logic [N-1:0] prefix
);

    localparam int LV = $clog2(N);

    logic [N-1:0] lvl [LV+1];

    always_comb
    begin
        lvl[0] = bits;
        for (int k = 0; k < LV; k++)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (i >= (1 << k))
                begin
                    lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
                end
                else
                begin
                    lvl[k+1][i] = lvl[k][i];
                end
            end
        end
    end

    assign prefix = lvl[LV];

endmodule

// File: rtl/sorted_event_priority_queue_unit.sv
// Top level of the sorted event priority queue: a chain of record cells.
//
// The queue holds up to CAPACITY job records sorted by event time, earliest
// in cell 0, as a row of identical cells that each compare their own time
// against the incoming key and shift left or right with their neighbors in
// the same cycle. An insert puts the record after every record of equal
// time, so equal times leave in arrival order; an insert into a full queue
// is dropped with status 2. Remove-head shifts the whole chain toward cell 0.
// Remove-by-key deletes only the first record in queue order whose job
// number matches, with status 3 when none does and status 1 on an empty
// queue. Every item produces exactly one response item with the head record
// after the operation (zeros when the queue is empty), the occupancy and the
// status. Insert, remove-head and the unused operation code complete in the
// cycle they are accepted; remove-by-key first registers the match flags of
// all cells, and the cycle after that resolves the first match through
// a prefix OR tree before the chain closes the gap. The response sits in an
// output register, so a new item is taken while the previous response is
// being consumed. Slot contents have no reset; only the per-cell valid bits,
// the count, the phase and the response valid flag are cleared.
module sorted_event_priority_queue_unit import sepq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input logic        clk,
    input logic        rst_n,
    sepq_req_if.sink   request,
    sepq_rsp_if.source response
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        PH_READY,
        PH_DELETE
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [CAPACITY-1:0] match_reg;

    record_t            head_reg;
    logic               head_valid_reg;
    logic [OCC_W-1:0]   occ_reg;
    status_t            status_reg;

    // Chain signals.
    record_t             rec_arr       [CAPACITY];
    record_t             rec_next_arr  [CAPACITY];
    logic [CAPACITY-1:0] used_arr;
    logic [CAPACITY-1:0] used_next_arr;
    logic [CAPACITY-1:0] greater_arr;
    logic [CAPACITY-1:0] match_arr;
    logic [CAPACITY-1:0] prefix;
    logic [CAPACITY-1:0] sel;

    record_t new_rec;
    cmd_t    cmd;
    op_t     op;
    logic    accept;
    logic    load;
    status_t status_new;

    assign op     = op_t'(request.operation);
    assign accept = request.valid && request.ready;
    assign request.ready = (phase_reg == PH_READY) && (!out_valid_reg || response.ready);

    assign new_rec = '{
        event_time:   request.event_time,
        job_id:       request.job_id,
        job_kind:     request.job_kind,
        kind_serial:  request.kind_serial,
        service_time: request.service_time,
        waited_time:  request.waited_time
    };

    // The row of cells; each sees its two neighbors, the broadcast and its own select bit.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        record_t left_rec_w;
        logic    left_used_w;
        logic    left_greater_w;
        record_t right_rec_w;
        logic    right_used_w;

        if (i == 0)
        begin : g_first
            assign left_rec_w     = new_rec;
            assign left_used_w    = 1'b0;
            assign left_greater_w = 1'b0;
        end
        else
        begin : g_mid_l
            assign left_rec_w     = rec_arr[i-1];
            assign left_used_w    = used_arr[i-1];
            assign left_greater_w = greater_arr[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_rec_w  = rec_arr[i];
            assign right_used_w = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_rec_w  = rec_arr[i+1];
            assign right_used_w = used_arr[i+1];
        end

        sepq_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .new_rec      (new_rec),
            .key_job      (request.job_id),
            .sel          (sel[i]),
            .left_greater (left_greater_w),
            .left_rec     (left_rec_w),
            .left_used    (left_used_w),
            .right_rec    (right_rec_w),
            .right_used   (right_used_w),
            .rec          (rec_arr[i]),
            .used         (used_arr[i]),
            .greater      (greater_arr[i]),
            .match        (match_arr[i]),
            .rec_next     (rec_next_arr[i]),
            .used_next    (used_next_arr[i])
        );
    end

    // Every cell at or after the first registered match closes the gap.
    sepq_prefix #(
        .N (CAPACITY)
    ) u_prefix (
        .bits   (match_reg),
        .prefix (prefix)
    );

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        cmd        = '{ins_go: 1'b0, del_go: 1'b0};
        sel        = prefix;
        load       = 1'b0;
        status_new = ST_OK;

        if (phase_reg == PH_DELETE)
        begin
            load       = 1'b1;
            phase_next = PH_READY;
            cmd.del_go = 1'b1;
            if (!used_arr[0])
            begin
                status_new = ST_EMPTY;
            end
            else if (!prefix[CAPACITY-1])
            begin
                status_new = ST_NOKEY;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
        else if (accept)
        begin
            unique case (op)
                OP_INSERT:
                begin
                    load = 1'b1;
                    if (used_arr[CAPACITY-1])
                    begin
                        status_new = ST_FULL;
                    end
                    else
                    begin
                        cmd.ins_go = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_POP:
                begin
                    load = 1'b1;
                    sel  = '1;
                    if (!used_arr[0])
                    begin
                        status_new = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.del_go = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_DELETE:
                begin
                    phase_next = PH_DELETE;
                end
                OP_NONE:
                begin
                    load = 1'b1;
                end
                default:
                begin
                    load = 1'b1;
                end
            endcase
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_READY;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Match flags and the response payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_DELETE))
        begin
            match_reg <= match_arr;
        end
        if (load)
        begin
            head_valid_reg <= used_next_arr[0];
            head_reg       <= used_next_arr[0] ? rec_next_arr[0] : '0;
            occ_reg        <= OCC_W'(count_next);
            status_reg     <= status_new;
        end
    end

    assign response.valid            = out_valid_reg;
    assign response.head_valid       = head_valid_reg;
    assign response.head_time        = head_reg.event_time;
    assign response.head_job         = head_reg.job_id;
    assign response.head_kind        = head_reg.job_kind;
    assign response.head_kind_serial = head_reg.kind_serial;
    assign response.head_service     = head_reg.service_time;
    assign response.head_waited      = head_reg.waited_time;
    assign response.occupancy        = occ_reg;
    assign response.status           = status_reg;

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the sorted event priority queue unit.
module tb_top;

    import sepq_pkg::*;

    // The queue depth under test. The bench keeps its own copy of the queue at
    // this depth and predicts the response of every item from it.
    localparam int QUEUE_DEPTH   = 64;
    // No correct run comes near this cycle count.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int REPORT_LIMIT  = 10;

    // The head record, occupancy and status that one item should produce.
    typedef struct {
        logic             head_valid;
        record_t          head;
        logic [OCC_W-1:0] occupancy;
        status_t          status;
    } head_report_t;

    logic clk;
    logic rst_n;

    sepq_req_if req_ch ();
    sepq_rsp_if rsp_ch ();

    sorted_event_priority_queue_unit #(
        .CAPACITY (QUEUE_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    // The bench's copy of the event list, earliest record in entry 0.
    record_t      ev_store [QUEUE_DEPTH];
    int           ev_count;
    // Head reports still owed by the block, oldest first.
    head_report_t expected_heads [$];

    int  cycle_count;
    int  items_sent;
    int  responses_checked;
    int  mismatch_count;
    int  unexpected_count;
    int  full_drops;
    int  empty_removes;
    int  missing_keys;
    int  peak_occupancy;

    // Sender pacing: items go out in bursts, with random gaps between bursts
    // unless the current phase runs the sender without pauses.
    int  burst_left;
    bit  sender_steady;

    // Receiver pacing: a stall mode and the number of cycles it still lasts.
    int  stall_mode;
    int  stall_left;
    int  stall_phase;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Removes the record at position pos and closes the gap behind it.
    function automatic void drop_record(int pos);
        for (int i = pos; i < ev_count - 1; i++) begin
            ev_store[i] = ev_store[i + 1];
        end
        ev_count--;
    endfunction

    // Applies one queue operation to the bench's copy and returns the report
    // that the block must give for it. An insert goes after every record
    // whose time is equal or earlier, so equal times leave in arrival order.
    // Remove-by-key drops only the first record in queue order that matches.
    function automatic head_report_t apply_queue_op(op_t op, record_t rec);
        head_report_t report;
        int           pos;
        status_t      st;

        st = ST_OK;
        case (op)
            OP_INSERT: begin
                if (ev_count >= QUEUE_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < ev_count && ev_store[pos].event_time <= rec.event_time) begin
                        pos++;
                    end
                    for (int i = ev_count; i > pos; i--) begin
                        ev_store[i] = ev_store[i - 1];
                    end
                    ev_store[pos] = rec;
                    ev_count++;
                end
            end
            OP_POP: begin
                if (ev_count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    drop_record(0);
                end
            end
            OP_DELETE: begin
                if (ev_count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < ev_count && ev_store[pos].job_id != rec.job_id) begin
                        pos++;
                    end
                    if (pos < ev_count) begin
                        drop_record(pos);
                    end else begin
                        st = ST_NOKEY;
                    end
                end
            end
            default: begin
                // The unused code leaves the queue alone and reports ok.
            end
        endcase

        report.head_valid = (ev_count > 0);
        report.head       = (ev_count > 0) ? ev_store[0] : '0;
        report.occupancy  = ev_count[OCC_W-1:0];
        report.status     = st;
        return report;
    endfunction

    function automatic record_t make_record(logic [31:0] t, logic [15:0] job,
                                            logic [7:0] kind, logic [15:0] serial,
                                            logic [15:0] service, logic [31:0] waited);
        record_t rec;

        rec.event_time   = t;
        rec.job_id       = job;
        rec.job_kind     = kind;
        rec.kind_serial  = serial;
        rec.service_time = service;
        rec.waited_time  = waited;
        return rec;
    endfunction

    // Random record content. Times come often from a small pool so that ties
    // are common, the rest from the whole range and its two ends. Job numbers
    // come mostly from a small pool so that duplicate keys occur.
    function automatic record_t random_record();
        record_t     rec;
        int          pick;
        logic [31:0] t;

        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            t = $urandom_range(0, 15);
        end else if (pick < 8) begin
            t = $urandom;
        end else if (pick == 8) begin
            t = 32'd0;
        end else begin
            t = 32'hFFFF_FFFF;
        end
        rec = make_record(t, 16'($urandom), 8'($urandom), 16'($urandom),
                          16'($urandom), $urandom);
        if ($urandom_range(0, 9) < 7) begin
            rec.job_id = 16'($urandom_range(0, 31));
        end
        return rec;
    endfunction

    // A removal key: usually the job number of a record that is held, so that
    // removals land at every position, otherwise any number.
    function automatic logic [15:0] pick_delete_key();
        if (ev_count > 0 && $urandom_range(0, 3) != 0) begin
            return ev_store[$urandom_range(0, ev_count - 1)].job_id;
        end
        return ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 31)) : 16'($urandom);
    endfunction

    // Holds the request channel idle by keeping valid low.
    task automatic hold_off_requests(int n);
        repeat (n) begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
    endtask

    // Sends one item and returns once the block has accepted it. The monitor
    // below updates the bench's queue copy at the accepting edge, so the next
    // item is chosen against the state that this one left behind.
    task automatic send_item(op_t op, record_t rec);
        int gap;

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = sender_steady ? 0 : $urandom_range(0, 6);
            hold_off_requests(gap);
        end
        burst_left--;

        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.event_time   <= rec.event_time;
        req_ch.job_id       <= rec.job_id;
        req_ch.job_kind     <= rec.job_kind;
        req_ch.kind_serial  <= rec.kind_serial;
        req_ch.service_time <= rec.service_time;
        req_ch.waited_time  <= rec.waited_time;
        do begin
            @(posedge clk);
        end while (req_ch.ready !== 1'b1);
        items_sent++;
    endtask

    // Sends a removal of the given key with random content in the fields that
    // a removal ignores.
    task automatic send_delete(logic [15:0] key);
        record_t rec;

        rec = random_record();
        rec.job_id = key;
        send_item(OP_DELETE, rec);
    endtask

    // Stops sending and waits until every owed response has come, then keeps
    // waiting so that nothing is left in flight.
    task automatic wait_until_settled();
        hold_off_requests(1);
        while (expected_heads.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Records an error for one field that differs from its prediction.
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("Mismatch in response %0d, %s: expected 0x%0h, got 0x%0h",
                         responses_checked, name, want, got);
            end
        end
    endfunction

    // Both handshakes are watched at the same rising edge. An accepted request
    // is predicted first, so that a response leaving at that very edge would
    // still find its expectation waiting.
    always @(posedge clk) begin : watch_channels
        record_t      got_rec;
        head_report_t owed;

        if (rst_n === 1'b1 && req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            got_rec = make_record(req_ch.event_time, req_ch.job_id, req_ch.job_kind,
                                  req_ch.kind_serial, req_ch.service_time,
                                  req_ch.waited_time);
            owed = apply_queue_op(op_t'(req_ch.operation), got_rec);
            expected_heads.push_back(owed);
            case (owed.status)
                ST_FULL:  full_drops++;
                ST_EMPTY: empty_removes++;
                ST_NOKEY: missing_keys++;
                default:  ;
            endcase
            if (ev_count > peak_occupancy) begin
                peak_occupancy = ev_count;
            end
        end

        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_heads.size() == 0) begin
                unexpected_count++;
                if (unexpected_count + mismatch_count <= REPORT_LIMIT) begin
                    $display("Response with no item waiting for it, after %0d checked",
                             responses_checked);
                end
            end else begin
                owed = expected_heads.pop_front();
                check_field("head_valid", owed.head_valid, rsp_ch.head_valid);
                check_field("head_time", owed.head.event_time, rsp_ch.head_time);
                check_field("head_job", owed.head.job_id, rsp_ch.head_job);
                check_field("head_kind", owed.head.job_kind, rsp_ch.head_kind);
                check_field("head_kind_serial", owed.head.kind_serial,
                            rsp_ch.head_kind_serial);
                check_field("head_service", owed.head.service_time, rsp_ch.head_service);
                check_field("head_waited", owed.head.waited_time, rsp_ch.head_waited);
                check_field("occupancy", owed.occupancy, rsp_ch.occupancy);
                check_field("status", owed.status, rsp_ch.status);
                responses_checked++;
            end
        end
    end

    // The receiver stalls on a pattern of its own that changes at random
    // intervals: always ready, random stalls, a fixed rhythm, or long
    // stalls with ready seldom high.
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        stall_phase++;
        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            2:       rsp_ch.ready <= (stall_phase % 3 != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Guard against a hang: a correct run ends long before this count.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d responses still owed",
                     cycle_count, expected_heads.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Removals of both kinds and the unused code on an empty queue.
    task automatic test_empty_queue_ops();
        send_item(OP_POP, random_record());
        send_delete(16'h0000);
        send_item(OP_NONE, random_record());
        wait_until_settled();
    endtask

    // Extremes of every field, ties in time, duplicate job numbers, removal by
    // key at the head, in the middle and at the tail, and a key that is not
    // held. The queue ends empty.
    task automatic test_order_and_ties();
        send_item(OP_INSERT, make_record(32'hFFFF_FFFF, 16'd1, 8'h00, 16'h0000,
                                         16'h0000, 32'h0000_0000));
        send_item(OP_INSERT, make_record(32'h0000_0000, 16'hFFFF, 8'hFF, 16'hFFFF,
                                         16'hFFFF, 32'hFFFF_FFFF));
        // Three equal times must leave in the order they arrived.
        send_item(OP_INSERT, make_record(32'd5, 16'd10, 8'h5A, 16'd1, 16'd100, 32'd7));
        send_item(OP_INSERT, make_record(32'd5, 16'd11, 8'hA5, 16'd2, 16'd200, 32'd8));
        send_item(OP_INSERT, make_record(32'd5, 16'd12, 8'h3C, 16'd3, 16'd300, 32'd9));
        // An earlier record that shares a job number with a later one.
        send_item(OP_INSERT, make_record(32'd3, 16'd11, 8'hC3, 16'd4, 16'd400, 32'd10));
        send_item(OP_NONE, random_record());
        // Only the first job 11 in queue order goes, the one at time 3.
        send_delete(16'd11);
        send_delete(16'h7777);
        send_delete(16'hFFFF);
        send_item(OP_POP, random_record());
        // A new equal time lands behind the equal records already held.
        send_item(OP_INSERT, make_record(32'd5, 16'd13, 8'h0F, 16'd5, 16'd500, 32'd11));
        send_delete(16'd12);
        send_delete(16'd1);
        send_item(OP_POP, random_record());
        send_item(OP_POP, random_record());
        send_item(OP_POP, random_record());
        wait_until_settled();
    endtask

    // Fills the queue to capacity, drops inserts on a full queue, works at the
    // full mark for a while and then empties the queue by removing the head.
    task automatic test_full_queue();
        while (ev_count < QUEUE_DEPTH) begin
            send_item(OP_INSERT, random_record());
        end
        repeat (3) send_item(OP_INSERT, random_record());
        send_delete(pick_delete_key());
        send_item(OP_INSERT, random_record());
        send_item(OP_POP, random_record());
        send_item(OP_INSERT, random_record());
        send_item(OP_INSERT, random_record());
        while (ev_count > 0) begin
            send_item(OP_POP, random_record());
        end
        send_item(OP_POP, random_record());
        send_delete(pick_delete_key());
        wait_until_settled();
    endtask

    // Random traffic in phases that lean toward filling, holding steady or
    // draining the queue, so the occupancy sweeps its whole range. Each phase
    // ends by waiting for every owed response.
    task automatic test_random_traffic(int item_goal);
        int      phase_len;
        int      insert_pct;
        int      roll;
        record_t rec;

        while (items_sent < item_goal) begin
            phase_len     = $urandom_range(60, 250);
            sender_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       insert_pct = 75;
                1:       insert_pct = 50;
                default: insert_pct = 25;
            endcase
            repeat (phase_len) begin
                rec  = random_record();
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    send_item(OP_NONE, rec);
                end else if (roll < 3 + insert_pct) begin
                    send_item(OP_INSERT, rec);
                end else if ($urandom_range(0, 1) == 1) begin
                    send_item(OP_POP, rec);
                end else begin
                    send_delete(pick_delete_key());
                end
            end
            wait_until_settled();
        end
        sender_steady = 1'b0;
    endtask

    initial begin
        ev_count          = 0;
        cycle_count       = 0;
        items_sent        = 0;
        responses_checked = 0;
        mismatch_count    = 0;
        unexpected_count  = 0;
        full_drops        = 0;
        empty_removes     = 0;
        missing_keys      = 0;
        peak_occupancy    = 0;
        burst_left        = 0;
        sender_steady     = 1'b0;
        stall_mode        = 0;
        stall_left        = 0;
        stall_phase       = 0;

        // Every input of the block is known from time zero.
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_NONE;
        req_ch.event_time   = '0;
        req_ch.job_id       = '0;
        req_ch.job_kind     = '0;
        req_ch.kind_serial  = '0;
        req_ch.service_time = '0;
        req_ch.waited_time  = '0;
        rsp_ch.ready        = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_queue_ops();
        test_order_and_ties();
        test_full_queue();
        test_random_traffic(items_sent + RANDOM_ITEMS);

        $display("Run covered %0d items: %0d inserts dropped on a full queue, %0d removals on empty, %0d keys not found, peak occupancy %0d of %0d.",
                 items_sent, full_drops, empty_removes, missing_keys,
                 peak_occupancy, QUEUE_DEPTH);
        $display("Checked %0d responses: %0d field mismatches, %0d unexpected responses.",
                 responses_checked, mismatch_count, unexpected_count);
        if (mismatch_count == 0 && unexpected_count == 0 && expected_heads.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
